// ===== hdl/sorted_list_symmetric_difference_assert.svh =====
// Assertion macros for the sorted-list symmetric difference block.
// Included by the RTL files that carry checks; depends on nothing else.
`ifndef SORTED_LIST_SYMMETRIC_DIFFERENCE_ASSERT_SVH
`define SORTED_LIST_SYMMETRIC_DIFFERENCE_ASSERT_SVH

`ifndef ASSERT_OFF
// Property that must hold at every clock edge outside reset
`define SLSD_ASSERT(lbl, clk, rstn, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
		else $error("slsd: property failed");
// Condition that must never be true outside reset
`define SLSD_ASSERT_NEVER(lbl, clk, rstn, expr) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) \
		else $error("slsd: forbidden condition seen");
`else
`define SLSD_ASSERT(lbl, clk, rstn, prop)
`define SLSD_ASSERT_NEVER(lbl, clk, rstn, expr)
`endif

`endif

// ===== hdl/slsd_pkg.sv =====
// Shared types and constants for the sorted-list symmetric difference block.
// No dependencies.
`default_nettype none

package slsd_pkg;

	localparam int CAPACITY_DEF   = 16;
	localparam int VALUE_BITS_DEF = 16;
	localparam int MAX_RESULTS    = 32;
	localparam int EW             = $clog2(MAX_RESULTS + 1);
	localparam logic [7:0] DIVISOR_RESET = 8'd5;

	typedef enum logic [1:0] {
		OP_APPEND_A = 2'd0,
		OP_APPEND_B = 2'd1,
		OP_RUN      = 2'd2,
		OP_NONE     = 2'd3
	} op_t;

	typedef struct packed {
		op_t         op;
		logic [15:0] value;
	} slsd_item_t;

	typedef struct packed {
		logic [15:0] value_res;
		logic        empty_res;
		logic        overflow;
		logic        last;
	} slsd_result_t;

	// Response of the remainder unit
	typedef struct packed {
		logic done;
		logic multiple;
	} slsd_mod_rsp_t;

endpackage

`default_nettype wire

// ===== hdl/slsd_list_mem.sv =====
// One list store: synchronous memory, one write port, one registered read port.
// Uses slsd_pkg for the default depth and width.
`default_nettype none

module slsd_list_mem import slsd_pkg::*; #(
	parameter int DEPTH = CAPACITY_DEF,
	parameter int WIDTH = VALUE_BITS_DEF
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write on append
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Registered read
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

// ===== hdl/slsd_mod_unit.sv =====
// Bit-serial remainder unit: tests whether a value is a multiple of the divisor.
// Depends on slsd_pkg for the response type.
`default_nettype none

module slsd_mod_unit import slsd_pkg::*; #(
	parameter int VALUE_BITS = VALUE_BITS_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  start,
	input  wire logic [VALUE_BITS-1:0] x,
	input  wire logic [7:0]            divisor,
	output slsd_mod_rsp_t              rsp
);

	localparam int SW = $clog2(VALUE_BITS);

	logic                  run_q;
	logic                  done_q;
	logic [SW-1:0]         cnt_q;
	logic [VALUE_BITS-1:0] sh_q;
	logic [7:0]            rem_q;
	logic                  zero_q;
	logic [8:0]            trial;

	// Shift in the next dividend bit
	assign trial = {rem_q, sh_q[VALUE_BITS-1]};

	// Control: count one bit per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= SW'(VALUE_BITS - 1);
			end else if (run_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Datapath: restoring remainder
	always_ff @(posedge clk) begin
		if (start) begin
			sh_q   <= x;
			rem_q  <= '0;
			zero_q <= (x == '0);
		end else if (run_q) begin
			sh_q <= sh_q << 1;
			if (trial >= {1'b0, divisor}) begin
				rem_q <= 8'(trial - {1'b0, divisor});
			end else begin
				rem_q <= trial[7:0];
			end
		end
	end

	assign rsp.done     = done_q;
	assign rsp.multiple = (divisor == 8'd0) ? zero_q : (rem_q == 8'd0);

endmodule

`default_nettype wire

// ===== hdl/sorted_list_symmetric_difference.sv =====
// Top level: two list stores, the scan/emit sequencer and the remainder unit.
// Depends on slsd_pkg, slsd_list_mem, slsd_mod_unit and the assertion header.
//
// Appends (op 0, op 1) can be issued back to back.
// A run (op 2) finds the distinct values in ascending order by repeated scans
// of both stores: each scan reads one entry of each list per cycle. A value
// present in only one list is then tested in the bit-serial remainder unit.
// Results leave one per strobe and cannot be stalled; the final one carries
// last, and busy drops in the cycle it shows.
`default_nettype none

module sorted_list_symmetric_difference import slsd_pkg::*; #(
	parameter int CAPACITY   = CAPACITY_DEF,
	parameter int VALUE_BITS = VALUE_BITS_DEF
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       start,
	output logic            busy,
	input  wire slsd_item_t item,
	input  wire logic       divisor_we,
	input  wire logic [7:0] divisor_wdata,
	output logic            result_stb,
	output slsd_result_t    result
);

	`include "sorted_list_symmetric_difference_assert.svh"

	localparam int AW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);

	typedef enum logic [4:0] {
		ST_IDLE   = 5'b00001,
		ST_SCAN   = 5'b00010,
		ST_DIV    = 5'b00100,
		ST_EMIT   = 5'b01000,
		ST_FINISH = 5'b10000
	} state_t;

	state_t                state_q;
	logic [7:0]            divisor_q;
	logic [CW-1:0]         count_a_q, count_b_q;
	logic                  dropped_q;
	logic [CW-1:0]         idx_q;
	logic                  rd_vld_s1, va_s1, vb_s1;
	logic                  found_q;
	logic [VALUE_BITS-1:0] best_q, prev_q, pend_q;
	logic [CW-1:0]         ca_q, cb_q, rep_q;
	logic                  have_prev_q, pend_vld_q;
	logic [EW-1:0]         emit_cnt_q;
	logic                  result_stb_q;
	slsd_result_t          result_q;

	logic [VALUE_BITS-1:0] in_val, rdata_a, rdata_b;
	logic [CW-1:0]         scan_n;
	logic                  accept, issue, scan_done, mod_start;
	logic                  we_a, we_b;
	logic                  f1, f2;
	logic [VALUE_BITS-1:0] b1, b2;
	logic [CW-1:0]         ca1, cb1, ca2, cb2;
	slsd_mod_rsp_t         mod_rsp;

	// Fit the incoming value to the stored width
	assign in_val = VALUE_BITS'(item.value);

	assign busy      = (state_q != ST_IDLE);
	assign accept    = start && !busy;
	assign scan_n    = (count_a_q > count_b_q) ? count_a_q : count_b_q;
	assign issue     = (state_q == ST_SCAN) && (idx_q < scan_n);
	assign scan_done = (state_q == ST_SCAN) && !issue && !rd_vld_s1;
	assign mod_start = scan_done && found_q && ((ca_q == '0) || (cb_q == '0));
	assign we_a = accept && (item.op == OP_APPEND_A) && (count_a_q < CW'(CAPACITY));
	assign we_b = accept && (item.op == OP_APPEND_B) && (count_b_q < CW'(CAPACITY));

	slsd_list_mem #(.DEPTH(CAPACITY), .WIDTH(VALUE_BITS)) u_mem_a (
		.clk  (clk),
		.we   (we_a),
		.waddr(count_a_q[AW-1:0]),
		.wdata(in_val),
		.re   (issue),
		.raddr(idx_q[AW-1:0]),
		.rdata(rdata_a)
	);

	slsd_list_mem #(.DEPTH(CAPACITY), .WIDTH(VALUE_BITS)) u_mem_b (
		.clk  (clk),
		.we   (we_b),
		.waddr(count_b_q[AW-1:0]),
		.wdata(in_val),
		.re   (issue),
		.raddr(idx_q[AW-1:0]),
		.rdata(rdata_b)
	);

	slsd_mod_unit #(.VALUE_BITS(VALUE_BITS)) u_mod (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mod_start),
		.x      (best_q),
		.divisor(divisor_q),
		.rsp    (mod_rsp)
	);

	// Track the smallest value above the previous one, and its count per list
	always_comb begin
		f1  = found_q;
		b1  = best_q;
		ca1 = ca_q;
		cb1 = cb_q;
		if (va_s1 && (!have_prev_q || (rdata_a > prev_q))) begin
			if (!found_q || (rdata_a < best_q)) begin
				f1  = 1'b1;
				b1  = rdata_a;
				ca1 = CW'(1);
				cb1 = '0;
			end else if (rdata_a == best_q) begin
				ca1 = ca_q + 1'b1;
			end
		end
		f2  = f1;
		b2  = b1;
		ca2 = ca1;
		cb2 = cb1;
		if (vb_s1 && (!have_prev_q || (rdata_b > prev_q))) begin
			if (!f1 || (rdata_b < b1)) begin
				f2  = 1'b1;
				b2  = rdata_b;
				ca2 = '0;
				cb2 = CW'(1);
			end else if (rdata_b == b1) begin
				cb2 = cb1 + 1'b1;
			end
		end
	end

	// Sequencer and control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			divisor_q    <= DIVISOR_RESET;
			count_a_q    <= '0;
			count_b_q    <= '0;
			dropped_q    <= 1'b0;
			idx_q        <= '0;
			rd_vld_s1    <= 1'b0;
			va_s1        <= 1'b0;
			vb_s1        <= 1'b0;
			found_q      <= 1'b0;
			ca_q         <= '0;
			cb_q         <= '0;
			rep_q        <= '0;
			have_prev_q  <= 1'b0;
			pend_vld_q   <= 1'b0;
			emit_cnt_q   <= '0;
			result_stb_q <= 1'b0;
		end else begin
			result_stb_q <= 1'b0;
			if (divisor_we) begin
				divisor_q <= divisor_wdata;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						case (item.op)
							OP_APPEND_A: begin
								if (we_a) count_a_q <= count_a_q + 1'b1;
								else dropped_q <= 1'b1;
							end
							OP_APPEND_B: begin
								if (we_b) count_b_q <= count_b_q + 1'b1;
								else dropped_q <= 1'b1;
							end
							OP_RUN: begin
								state_q     <= ST_SCAN;
								have_prev_q <= 1'b0;
								emit_cnt_q  <= '0;
								idx_q       <= '0;
								rd_vld_s1   <= 1'b0;
								found_q     <= 1'b0;
								ca_q        <= '0;
								cb_q        <= '0;
							end
							default: ;
						endcase
					end
				end
				ST_SCAN: begin
					// Issue one read per list, fold the returning pair
					if (issue) begin
						idx_q     <= idx_q + 1'b1;
						rd_vld_s1 <= 1'b1;
						va_s1     <= (idx_q < count_a_q);
						vb_s1     <= (idx_q < count_b_q);
					end else begin
						rd_vld_s1 <= 1'b0;
					end
					if (rd_vld_s1) begin
						found_q <= f2;
						ca_q    <= ca2;
						cb_q    <= cb2;
					end
					if (scan_done) begin
						if (!found_q) begin
							state_q <= ST_FINISH;
						end else begin
							have_prev_q <= 1'b1;
							if (mod_start) begin
								state_q <= ST_DIV;
							end else begin
								idx_q   <= '0;
								found_q <= 1'b0;
								ca_q    <= '0;
								cb_q    <= '0;
							end
						end
					end
				end
				ST_DIV: begin
					if (mod_rsp.done) begin
						if (mod_rsp.multiple) begin
							state_q <= ST_EMIT;
							rep_q   <= ca_q | cb_q;
						end else begin
							state_q <= ST_SCAN;
							idx_q   <= '0;
							found_q <= 1'b0;
							ca_q    <= '0;
							cb_q    <= '0;
						end
					end
				end
				ST_EMIT: begin
					// Release the held result, hold this copy back
					result_stb_q <= pend_vld_q;
					pend_vld_q   <= 1'b1;
					emit_cnt_q   <= emit_cnt_q + 1'b1;
					rep_q        <= rep_q - 1'b1;
					if (emit_cnt_q == EW'(MAX_RESULTS - 1)) begin
						state_q <= ST_FINISH;
					end else if (rep_q == CW'(1)) begin
						state_q <= ST_SCAN;
						idx_q   <= '0;
						found_q <= 1'b0;
						ca_q    <= '0;
						cb_q    <= '0;
					end
				end
				ST_FINISH: begin
					result_stb_q <= 1'b1;
					count_a_q    <= '0;
					count_b_q    <= '0;
					dropped_q    <= 1'b0;
					pend_vld_q   <= 1'b0;
					have_prev_q  <= 1'b0;
					emit_cnt_q   <= '0;
					state_q      <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (rd_vld_s1) begin
			best_q <= b2;
		end
		if (scan_done && found_q) begin
			prev_q <= best_q;
		end
		if (state_q == ST_EMIT) begin
			pend_q <= best_q;
			if (pend_vld_q) begin
				result_q.value_res <= 16'(pend_q);
				result_q.empty_res <= 1'b0;
				result_q.overflow  <= dropped_q;
				result_q.last      <= 1'b0;
			end
		end
		if (state_q == ST_FINISH) begin
			result_q.value_res <= pend_vld_q ? 16'(pend_q) : 16'd0;
			result_q.empty_res <= !pend_vld_q;
			result_q.overflow  <= dropped_q;
			result_q.last      <= 1'b1;
		end
	end

	assign result_stb = result_stb_q;
	assign result     = result_q;

	`SLSD_ASSERT(a_last_ends_run, clk, arst_n, (result_stb && result.last) |-> !busy)
	`SLSD_ASSERT(a_stb_in_run, clk, arst_n, result_stb |-> $past(busy))
	`SLSD_ASSERT(a_emit_bound, clk, arst_n, emit_cnt_q <= EW'(MAX_RESULTS))
	`SLSD_ASSERT(a_count_cap, clk, arst_n, (count_a_q <= CW'(CAPACITY)) && (count_b_q <= CW'(CAPACITY)))
	`SLSD_ASSERT_NEVER(a_mid_result_idle, clk, arst_n, result_stb && !result.last && !busy)

endmodule

`default_nettype wire

// ===== bench/tb_top.sv =====
// Self-checking bench for sorted_list_symmetric_difference: directed and random list loads and runs.
// Depends on slsd_pkg and the RTL top; predicts every result and compares it field by field.
`default_nettype none

module tb_top;
	import slsd_pkg::*;

	localparam int LIST_DEPTH = 16;
	localparam int STALL_LIMIT = 20000;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         start = 1'b0;
	logic         busy;
	slsd_item_t   item = '0;
	logic         divisor_we = 1'b0;
	logic   [7:0] divisor_wdata = '0;
	logic         result_stb;
	slsd_result_t result;

	sorted_list_symmetric_difference i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.item         (item),
		.divisor_we   (divisor_we),
		.divisor_wdata(divisor_wdata),
		.result_stb   (result_stb),
		.result       (result)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// shadow of the block's state
	logic [15:0]  store_a [LIST_DEPTH];
	logic [15:0]  store_b [LIST_DEPTH];
	int           fill_a = 0;
	int           fill_b = 0;
	bit           lost_append = 1'b0;
	logic [7:0]   divisor_shadow = DIVISOR_RESET;

	slsd_item_t   pending_items[$];
	slsd_result_t expected_results[$];
	int           errors = 0;
	int           idle_pct = 0;
	int           quiet_cycles = 0;

	function automatic bit is_multiple(logic [15:0] x);
		if (divisor_shadow == 0)
			return x == 0;
		return (x % divisor_shadow) == 0;
	endfunction

	// True when x occurs anywhere in the list
	function automatic bit in_list(logic [15:0] q[$], logic [15:0] x);
		foreach (q[k])
			if (q[k] == x)
				return 1'b1;
		return 1'b0;
	endfunction

	// Emit one result per element found only in its own list and divisible by the divisor
	function automatic void run_symmetric_difference();
		logic [15:0]  sa[$];
		logic [15:0]  sb[$];
		slsd_result_t r;
		int           i;
		int           j;
		int           n;
		bit           take_a;
		logic [15:0]  x;
		i = 0;
		j = 0;
		n = 0;
		for (int k = 0; k < fill_a; k++) sa.push_back(store_a[k]);
		for (int k = 0; k < fill_b; k++) sb.push_back(store_b[k]);
		sa.sort();
		sb.sort();
		while (i < fill_a || j < fill_b) begin
			if (i < fill_a && j < fill_b)
				take_a = sa[i] < sb[j];
			else
				take_a = i < fill_a;
			if (take_a) begin
				x = sa[i];
				i++;
				take_a = !in_list(sb, x);
			end else begin
				x = sb[j];
				j++;
				take_a = !in_list(sa, x);
			end
			if (take_a && is_multiple(x) && n < MAX_RESULTS) begin
				r = '{value_res: x, empty_res: 1'b0, overflow: lost_append, last: 1'b0};
				expected_results.push_back(r);
				n++;
			end
		end
		if (n == 0) begin
			r = '{value_res: '0, empty_res: 1'b1, overflow: lost_append, last: 1'b1};
			expected_results.push_back(r);
		end else begin
			expected_results[$].last = 1'b1;
		end
		fill_a = 0;
		fill_b = 0;
		lost_append = 1'b0;
	endfunction

	function automatic void apply_item(slsd_item_t it);
		case (it.op)
			OP_APPEND_A: begin
				if (fill_a < LIST_DEPTH) begin
					store_a[fill_a] = it.value;
					fill_a++;
				end else begin
					lost_append = 1'b1;
				end
			end
			OP_APPEND_B: begin
				if (fill_b < LIST_DEPTH) begin
					store_b[fill_b] = it.value;
					fill_b++;
				end else begin
					lost_append = 1'b1;
				end
			end
			OP_RUN: run_symmetric_difference();
			default: ;
		endcase
	endfunction

	// Driver: present items, advance on transfer, idle at random
	always @(posedge clk) begin
		bit taken;
		taken = start && !busy;
		if (taken) begin
			apply_item(item);
			void'(pending_items.pop_front());
		end
		if (!start || taken) begin
			if (pending_items.size() > 0 && $urandom_range(99) >= idle_pct) begin
				start <= 1'b1;
				item  <= pending_items[0];
			end else begin
				start <= 1'b0;
			end
		end
	end

	// Monitor: compare every strobed result against the oldest expectation
	always @(posedge clk) begin
		slsd_result_t exp_r;
		if (arst_n && result_stb) begin
			if (expected_results.size() == 0) begin
				$error("unexpected result: value_res %0d", result.value_res);
				errors++;
			end else begin
				exp_r = expected_results.pop_front();
				if (result.empty_res !== exp_r.empty_res) begin
					$error("empty_res: expected %0b, got %0b", exp_r.empty_res, result.empty_res);
					errors++;
				end
				if (!exp_r.empty_res && result.value_res !== exp_r.value_res) begin
					$error("value_res: expected %0d, got %0d", exp_r.value_res, result.value_res);
					errors++;
				end
				if (result.overflow !== exp_r.overflow) begin
					$error("overflow: expected %0b, got %0b", exp_r.overflow, result.overflow);
					errors++;
				end
				if (result.last !== exp_r.last) begin
					$error("last: expected %0b, got %0b", exp_r.last, result.last);
					errors++;
				end
			end
		end
	end

	// Watchdog: count cycles without any transfer
	always @(posedge clk) begin
		if ((start && !busy) || result_stb || divisor_we)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	task automatic push_item(op_t op, logic [15:0] v);
		slsd_item_t it;
		it.op = op;
		it.value = v;
		pending_items.push_back(it);
	endtask

	task automatic wait_drained();
		while (pending_items.size() > 0 || start || expected_results.size() > 0)
			@(posedge clk);
		repeat (60) @(posedge clk);
	endtask

	task automatic write_divisor(logic [7:0] d);
		@(posedge clk);
		divisor_we    <= 1'b1;
		divisor_wdata <= d;
		@(posedge clk);
		divisor_we    <= 1'b0;
		divisor_shadow = d;
	endtask

	// One well-formed load-and-run sequence with overlapping values
	task automatic push_run_sequence(logic [7:0] d, output int added);
		int          na;
		int          nb;
		logic [15:0] pool[8];
		logic [15:0] v;
		added = 0;
		na = ($urandom_range(7) == 0) ? $urandom_range(17, 19) : $urandom_range(0, 8);
		nb = ($urandom_range(7) == 0) ? $urandom_range(17, 19) : $urandom_range(0, 8);
		foreach (pool[k])
			pool[k] = 16'(d * $urandom_range(0, 40));
		while (na > 0 || nb > 0) begin
			if ($urandom_range(5) == 0)
				v = 16'($urandom);
			else
				v = pool[$urandom_range(7)];
			if (na > 0 && (nb == 0 || $urandom_range(1))) begin
				push_item(OP_APPEND_A, v);
				na--;
			end else begin
				push_item(OP_APPEND_B, v);
				nb--;
			end
			added++;
			if ($urandom_range(15) == 0) begin
				push_item(OP_NONE, 16'($urandom));
			end
		end
		push_item(OP_RUN, 16'($urandom));
		added++;
	endtask

	initial begin
		logic [7:0] phase_divisor[5] = '{8'd5, 8'd1, 8'd255, 8'd0, 8'd3};
		int         phase_idle[5]    = '{0, 57, 0, 31, 57};
		int         total;
		int         added;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// directed: extremes, duplicates, shared values, ignored op, empty run
		push_item(OP_APPEND_A, 16'd0);
		push_item(OP_APPEND_A, 16'hFFFF);
		push_item(OP_APPEND_A, 16'd10);
		push_item(OP_APPEND_A, 16'd10);
		push_item(OP_APPEND_A, 16'd15);
		push_item(OP_APPEND_B, 16'd15);
		push_item(OP_APPEND_B, 16'd20);
		push_item(OP_APPEND_B, 16'd7);
		push_item(OP_NONE, 16'hFFFF);
		push_item(OP_RUN, 16'h0000);
		push_item(OP_RUN, 16'hFFFF);
		push_item(OP_APPEND_B, 16'd3);
		push_item(OP_RUN, 16'd0);
		wait_drained();

		for (int p = 0; p < 5; p++) begin
			if (p > 0)
				write_divisor(phase_divisor[p]);
			idle_pct = phase_idle[p];
			total = 0;
			while (total < 40) begin
				push_run_sequence(phase_divisor[p], added);
				total += added;
			end
			wait_drained();
		end

		if (errors == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

`default_nettype wire
